// ===== rtl/prmt_pkg.sv =====
// Shared types, codes and helpers of the plateau range max tracker.
package prmt_pkg;

  typedef enum logic [1:0] {
    ACT_SET   = 2'd0,
    ACT_ADD   = 2'd1,
    ACT_QUERY = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  // Classified item handed from the front part to the back part.
  typedef struct packed {
    action_t     act;
    logic [9:0]  pa;
    logic [10:0] lo;
    logic [10:0] hi;
    logic [31:0] amount;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_U_RD,
    ST_U_WR,
    ST_W_RD,
    ST_R_LEAF,
    ST_R_CLIMB,
    ST_Q_L,
    ST_Q_R,
    ST_Q_DONE,
    ST_Q_OUT
  } bstate_t;

  typedef struct packed {
    logic clearing;
    logic busy;
  } bstat_t;

  localparam logic [31:0] SIGN_FLIP      = 32'h8000_0000;
  localparam int          LEN_MIN        = 3;
  localparam int          LEN_RESET      = 1024;
  localparam logic        CFG_IDX_LENGTH = 1'b0;

  function automatic logic [32:0] key_max(input logic [32:0] a, input logic [32:0] b);
    return (a > b) ? a : b;
  endfunction

endpackage

// ===== rtl/prmt_ram.sv =====
// Generic simple dual-port RAM with registered read.
module prmt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/prmt_front.sv =====
// Front part: accepts items, drops those with no effect, queues the rest.
module prmt_front import prmt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [10:0] len,
  input  logic        clr_done,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,
  output logic        q_valid,
  input  logic        q_ready,
  output cmd_t        q_data
);

  action_t     act;
  logic [9:0]  pa;
  logic [9:0]  pb;
  logic [10:0] hi;
  logic [10:0] lo;
  logic        keep;
  cmd_t        cmd;
  logic        push;
  logic        pop;

  cmd_t        mem_r [2];
  logic        wptr_r, wptr_nxt;
  logic        rptr_r, rptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;

  always_comb begin
    act  = action_t'(in_tdata[1:0]);
    pa   = in_tdata[11:2];
    pb   = in_tdata[21:12];
    hi   = ({1'b0, pb} > (len - 11'd1)) ? (len - 11'd1) : {1'b0, pb};
    lo   = {1'b0, pa} + 11'd1;
    // an empty range collapses to lo == hi
    if (!(lo < hi)) begin
      lo = hi;
    end
    unique case (act)
      ACT_SET, ACT_ADD: keep = ({1'b0, pa} < len);
      ACT_QUERY:        keep = 1'b1;
      default:          keep = 1'b0;
    endcase
    cmd = '{act: act, pa: pa, lo: lo, hi: hi, amount: in_tdata[53:22]};
  end

  assign in_tready = clr_done && (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready && keep;
  assign q_valid   = (cnt_r != 2'd0);
  assign pop       = q_valid && q_ready;
  assign q_data    = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? ~wptr_r : wptr_r;
    rptr_nxt = pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= cmd;
    end
  end

endmodule

// ===== rtl/prmt_back.sv =====
// Back part: clears the stores, applies writes, refreshes marks, runs queries.
module prmt_back import prmt_pkg::*; #(
  parameter int MAX_POSITIONS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [10:0] len,
  input  logic        q_valid,
  output logic        q_ready,
  input  cmd_t        q_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_found,
  output logic [31:0] out_best,
  output bstat_t      stat
);

  localparam int PW = $clog2(MAX_POSITIONS);
  localparam int NW = $clog2(2 * MAX_POSITIONS);

  bstate_t        state_r, state_nxt;
  cmd_t           cmd_r, cmd_nxt;
  logic [2:0]     k_r, k_nxt;
  logic [1:0]     j_r, j_nxt;
  logic [31:0]    w_r [5];
  logic [31:0]    w_nxt [5];
  logic [NW-1:0]  node_r, node_nxt;
  logic [32:0]    cur_r, cur_nxt;
  logic [NW-1:0]  l_r, l_nxt;
  logic [NW-1:0]  r_r, r_nxt;
  logic [32:0]    best_r, best_nxt;
  logic           pend_r, pend_nxt;
  logic [NW-1:0]  clr_r, clr_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           out_found_r, out_found_nxt;
  logic [31:0]    out_best_r, out_best_nxt;

  logic           h_we, h_re;
  logic [PW-1:0]  h_waddr, h_raddr;
  logic [31:0]    h_wdata, h_rdata;
  logic           t_we, t_re;
  logic [NW-1:0]  t_waddr, t_raddr;
  logic [32:0]    t_wdata, t_rdata;

  int             ref_pos;
  logic           ref_ok;
  logic [32:0]    ref_key;
  logic [NW-1:0]  leaf;
  logic [NW-1:0]  parent;
  logic [32:0]    climb_val;
  logic           out_free;

  prmt_ram #(.WIDTH(32), .DEPTH(MAX_POSITIONS)) u_heights (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .re(h_re), .raddr(h_raddr), .rdata(h_rdata)
  );

  prmt_ram #(.WIDTH(33), .DEPTH(2 * MAX_POSITIONS)) u_tree (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .re(t_re), .raddr(t_raddr), .rdata(t_rdata)
  );

  always_comb begin
    ref_pos = int'(cmd_r.pa) - 1 + int'(j_r);
    ref_ok  = (ref_pos >= 1) && (ref_pos + 2 <= int'(len));
    if ((w_r[j_r] == w_r[3'(j_r) + 3'd1]) && (w_r[3'(j_r) + 3'd1] == w_r[3'(j_r) + 3'd2])) begin
      ref_key = {1'b1, w_r[3'(j_r) + 3'd1] ^ SIGN_FLIP};
    end else begin
      ref_key = '0;
    end
    leaf      = NW'(MAX_POSITIONS) + NW'(ref_pos);
    parent    = node_r >> 1;
    climb_val = key_max(cur_r, t_rdata);
    out_free  = !out_valid_r || out_ready;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:   if (clr_r == NW'(2 * MAX_POSITIONS - 1)) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (q_valid) begin
          state_nxt = (q_data.act == ACT_QUERY) ? ST_Q_L : ST_U_RD;
        end
      end
      ST_U_RD:    state_nxt = ST_U_WR;
      ST_U_WR:    state_nxt = ST_W_RD;
      ST_W_RD:    if (k_r == 3'd5) state_nxt = ST_R_LEAF;
      ST_R_LEAF: begin
        if (ref_ok) begin
          state_nxt = ST_R_CLIMB;
        end else if (j_r == 2'd2) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_R_CLIMB: begin
        if (parent == NW'(1)) begin
          state_nxt = (j_r == 2'd2) ? ST_IDLE : ST_R_LEAF;
        end
      end
      ST_Q_L:     state_nxt = (l_r >= r_r) ? ST_Q_DONE : ST_Q_R;
      ST_Q_R:     state_nxt = ST_Q_L;
      ST_Q_DONE:  state_nxt = ST_Q_OUT;
      ST_Q_OUT:   if (out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_CLEAR;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    cmd_nxt       = cmd_r;
    k_nxt         = k_r;
    j_nxt         = j_r;
    w_nxt         = w_r;
    node_nxt      = node_r;
    cur_nxt       = cur_r;
    l_nxt         = l_r;
    r_nxt         = r_r;
    best_nxt      = best_r;
    pend_nxt      = 1'b0;
    clr_nxt       = clr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_found_nxt = out_found_r;
    out_best_nxt  = out_best_r;
    q_ready       = 1'b0;
    h_we          = 1'b0;
    h_waddr       = PW'(cmd_r.pa);
    h_wdata       = '0;
    h_re          = 1'b0;
    h_raddr       = PW'(cmd_r.pa);
    t_we          = 1'b0;
    t_waddr       = leaf;
    t_wdata       = '0;
    t_re          = 1'b0;
    t_raddr       = leaf ^ NW'(1);
    // fold in a tree read issued last cycle
    if (pend_r) begin
      best_nxt = key_max(best_r, t_rdata);
    end
    unique case (state_r)
      ST_CLEAR: begin
        h_we    = 1'b1;
        h_waddr = clr_r[PW-1:0];
        t_we    = 1'b1;
        t_waddr = clr_r;
        clr_nxt = clr_r + NW'(1);
      end
      ST_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          cmd_nxt  = q_data;
          l_nxt    = NW'(q_data.lo) + NW'(MAX_POSITIONS);
          r_nxt    = NW'(q_data.hi) + NW'(MAX_POSITIONS);
          best_nxt = '0;
        end
      end
      ST_U_RD: begin
        h_re = 1'b1;
      end
      ST_U_WR: begin
        h_we    = 1'b1;
        h_wdata = (cmd_r.act == ACT_SET) ? cmd_r.amount : h_rdata + cmd_r.amount;
        k_nxt   = 3'd0;
      end
      ST_W_RD: begin
        // read positions pa-2 .. pa+2 into the window
        if (k_r < 3'd5) begin
          h_re    = 1'b1;
          h_raddr = PW'(cmd_r.pa) + PW'(k_r) - PW'(2);
        end
        if (k_r != 3'd0) begin
          w_nxt[k_r - 3'd1] = h_rdata;
        end
        k_nxt = k_r + 3'd1;
        j_nxt = 2'd0;
      end
      ST_R_LEAF: begin
        if (ref_ok) begin
          t_we     = 1'b1;
          t_waddr  = leaf;
          t_wdata  = ref_key;
          cur_nxt  = ref_key;
          node_nxt = leaf;
          t_re     = 1'b1;
          t_raddr  = leaf ^ NW'(1);
        end else begin
          j_nxt = j_r + 2'd1;
        end
      end
      ST_R_CLIMB: begin
        t_we     = 1'b1;
        t_waddr  = parent;
        t_wdata  = climb_val;
        cur_nxt  = climb_val;
        node_nxt = parent;
        if (parent == NW'(1)) begin
          j_nxt = j_r + 2'd1;
        end else begin
          t_re    = 1'b1;
          t_raddr = parent ^ NW'(1);
        end
      end
      ST_Q_L: begin
        if ((l_r < r_r) && l_r[0]) begin
          t_re     = 1'b1;
          t_raddr  = l_r;
          pend_nxt = 1'b1;
          l_nxt    = l_r + NW'(1);
        end
      end
      ST_Q_R: begin
        if (r_r[0]) begin
          t_re     = 1'b1;
          t_raddr  = r_r ^ NW'(1);
          pend_nxt = 1'b1;
        end
        l_nxt = l_r >> 1;
        r_nxt = r_r >> 1;
      end
      ST_Q_DONE: begin
      end
      ST_Q_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = best_r[32];
          out_best_nxt  = best_r[32] ? (best_r[31:0] ^ SIGN_FLIP) : 32'd0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    k_r         <= k_nxt;
    j_r         <= j_nxt;
    w_r         <= w_nxt;
    node_r      <= node_nxt;
    cur_r       <= cur_nxt;
    l_r         <= l_nxt;
    r_r         <= r_nxt;
    best_r      <= best_nxt;
    out_found_r <= out_found_nxt;
    out_best_r  <= out_best_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_found     = out_found_r;
  assign out_best      = out_best_r;
  assign stat.clearing = (state_r == ST_CLEAR);
  assign stat.busy     = (state_r != ST_IDLE) && (state_r != ST_CLEAR);

endmodule

// ===== rtl/plateau_range_max_tracker.sv =====
// Top level of the plateau range max tracker: config register, front, back.
//
// Items arrive on the in_ stream: set a height, add a delta to a height, or
// ask for the greatest plateau height strictly between two positions. Only a
// query gives a result, one item on the out_ stream; set, add, writes beyond
// length_in_use and the unused action give nothing.
// A front part takes items into a two-entry queue; a back part works them
// through single-port-read memories for the heights and the max tree.
// Update: the height is read, then written, then the five positions around it
// are read into a window; up to three marks are then refreshed, each by a tree
// climb of one tree level a cycle. Query: the two ends of the range climb the
// tree level by level. One item is worked at a time in the back part.
// After reset a clearing pass zeroes both memories; in_tready stays low until
// it ends. Configuration writes are taken anytime.
// A result waits in the output register while out_tready is low; the queue
// keeps taking items until it is full.
module plateau_range_max_tracker import prmt_pkg::*; #(
  parameter int MAX_POSITIONS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // action[1:0], position_a[11:2], position_b[21:12], amount[53:22], zero pad
  input  logic [55:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // found[0], best_height[32:1], zero pad
  output logic [39:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [10:0] len_r, len_nxt;
  logic        cfg_wr;
  logic        q_valid;
  logic        q_ready;
  cmd_t        q_data;
  logic        out_found;
  logic [31:0] out_best;
  bstat_t      stat;

  function automatic logic [10:0] clamp_len(input logic [10:0] v);
    if (int'(v) < LEN_MIN) begin
      return 11'(LEN_MIN);
    end
    if (int'(v) > MAX_POSITIONS) begin
      return 11'(MAX_POSITIONS);
    end
    return v;
  endfunction

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == CFG_IDX_LENGTH) ? {21'd0, len_r} : 32'd0;

  always_comb begin
    len_nxt = len_r;
    if (cfg_wr && (cfg_paddr[2] == CFG_IDX_LENGTH)) begin
      len_nxt = clamp_len(cfg_pwdata[10:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= clamp_len(11'(LEN_RESET));
    end else begin
      len_r <= len_nxt;
    end
  end

  prmt_front u_front (
    .clk(clk), .rst_n(rst_n), .len(len_r), .clr_done(!stat.clearing),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
  );

  prmt_back #(.MAX_POSITIONS(MAX_POSITIONS)) u_back (
    .clk(clk), .rst_n(rst_n), .len(len_r),
    .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .out_found(out_found), .out_best(out_best), .stat(stat)
  );

  assign out_tdata = {7'd0, out_best, out_found};

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    (int'(len_r) >= LEN_MIN) && (int'(len_r) <= MAX_POSITIONS))
    else $error("length register out of range");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    stat.clearing |-> !in_tready)
    else $error("item accepted during clearing pass");

  a_no_result_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result shown straight after reset");

  a_empty_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_found) |-> (out_best == 32'd0))
    else $error("not-found result carries a height");

endmodule

// ===== test/tb.sv =====
// Self-checking testbench of the plateau range max tracker: random and directed items.
module tb;
  import prmt_pkg::*;

  localparam int NPOS = 1024;
  localparam int LIMIT = 3_000_000;

  // Mirror of the heights and plateau marks; predicts query answers.
  class plateau_scoreboard;
    logic [31:0] heights[NPOS];
    logic [32:0] marks[NPOS];
    int unsigned len;
    logic        want_found[$];
    logic [31:0] want_height[$];
    int          mismatches;
    int          answers;

    function void clear();
      for (int i = 0; i < NPOS; i++) begin
        heights[i] = '0;
        marks[i] = '0;
      end
      len = NPOS;
      mismatches = 0;
      answers = 0;
    endfunction

    function void set_length(logic [10:0] v);
      len = (v < LEN_MIN) ? LEN_MIN : ((v > NPOS) ? NPOS : v);
    endfunction

    function void refresh(int p);
      if (p < 1 || p + 2 > len) return;
      if (heights[p-1] == heights[p] && heights[p] == heights[p+1])
        marks[p] = {1'b1, heights[p] ^ SIGN_FLIP};
      else
        marks[p] = '0;
    endfunction

    function void note_item(action_t act, logic [9:0] pa, logic [9:0] pb, logic [31:0] amt);
      int unsigned hi;
      logic [32:0] best;
      if (act == ACT_SET || act == ACT_ADD) begin
        if (pa >= len) return;
        heights[pa] = (act == ACT_SET) ? amt : heights[pa] + amt;
        if (pa >= 1) refresh(pa - 1);
        refresh(pa);
        refresh(pa + 1);
      end else if (act == ACT_QUERY) begin
        hi = (pb > len - 1) ? len - 1 : pb;
        best = '0;
        for (int unsigned p = pa + 1; p < hi; p++)
          if (marks[p] > best) best = marks[p];
        want_found = {want_found, best[32]};
        want_height = {want_height, (best[32] ? best[31:0] ^ SIGN_FLIP : 32'd0)};
      end
    endfunction

    function void check_answer(logic f, logic [31:0] h);
      logic ef;
      logic [31:0] eh;
      answers++;
      if (want_found.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result found=%0d height=%0d", f, $signed(h));
        return;
      end
      ef = want_found.pop_front();
      eh = want_height.pop_front();
      if (f !== ef || h !== eh) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected found=%0d height=%0d, got found=%0d height=%0d",
                   ef, $signed(eh), f, $signed(h));
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic in_tvalid = 0, in_tready;
  logic [55:0] in_tdata = '0;
  logic out_tvalid, out_tready = 0;
  logic [39:0] out_tdata;
  logic cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0, cfg_prdata;
  logic cfg_pready;

  plateau_scoreboard board;
  int cycles = 0;
  bit calm = 0;
  int items_sent = 0;

  plateau_range_max_tracker u_top (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout");
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side: random stall bursts, none near the end.
  initial begin
    int gap;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) board.check_answer(out_tdata[0], out_tdata[32:1]);
      if (!calm && $urandom_range(0, 9) == 0) begin
        out_tready <= 0;
        gap = $urandom_range(1, 19);
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1;
    end
  end

  task automatic write_length(logic [10:0] v);
    @(posedge clk);
    cfg_psel <= 1; cfg_pwrite <= 1; cfg_paddr <= 3'd4 * CFG_IDX_LENGTH;
    cfg_pwdata <= {21'd0, v};
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    board.set_length(v);
  endtask

  // Hold tvalid after an accept; drop it only before an idle burst or a drain.
  task automatic send(action_t act, logic [9:0] pa, logic [9:0] pb, logic [31:0] amt);
    int gap;
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 0;
      gap = $urandom_range(1, 19);
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {2'b00, amt, pb, pa, act};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_item(act, pa, pb, amt);
    items_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (board.want_found.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // Mostly plateau-building runs in a window, plus queries and noise.
  task automatic random_phase(int n, int unsigned len);
    int unsigned base, w;
    logic [31:0] v;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          base = $urandom_range(0, len - 1);
          v = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 7) - 4;
          for (int k = 0; k < 3; k++)
            send(ACT_SET, 10'((base + k) % len), 10'($urandom), v);
          i += 2;
        end
        3: send(ACT_ADD, 10'($urandom_range(0, len - 1)), 10'($urandom),
                ($urandom_range(0, 1) ? $urandom : $urandom_range(0, 3) - 1));
        4: send(action_t'($urandom_range(0, 3)), 10'($urandom), 10'($urandom), $urandom);
        5: send(ACT_SET, 10'($urandom_range(0, len - 1)), 10'($urandom),
                $urandom_range(0, 7) - 4);
        default: begin
          base = $urandom_range(0, len - 1);
          w = $urandom_range(0, 1) ? $urandom_range(0, 20) : $urandom_range(0, 1023);
          send(ACT_QUERY, 10'(base), 10'((base + w > 1023) ? 1023 : base + w), $urandom);
        end
      endcase
    end
  endtask

  initial begin
    board = new();
    board.clear();
    repeat (10) @(posedge clk);
    rst_n <= 1;
    // Directed: reset has no marks, extremes, wrap, ignored writes, action 3.
    send(ACT_QUERY, 10'd0, 10'd1023, 32'hFFFF_FFFF);
    drain();
    write_length(11'd5);
    send(ACT_SET, 10'd1, 10'd0, 32'h8000_0000);
    send(ACT_SET, 10'd2, 10'd0, 32'h8000_0000);
    send(ACT_SET, 10'd3, 10'd0, 32'h8000_0000);
    send(ACT_QUERY, 10'd0, 10'd1023, 32'd0);
    send(ACT_SET, 10'd5, 10'd0, 32'd7);
    send(ACT_SET, 10'd1023, 10'd1023, 32'd7);
    send(ACT_ADD, 10'd2, 10'd0, 32'hFFFF_FFFF);
    send(ACT_ADD, 10'd2, 10'd0, 32'd1);
    send(ACT_NONE, 10'h3FF, 10'h3FF, 32'hFFFF_FFFF);
    send(ACT_QUERY, 10'd2, 10'd2, 32'd0);
    send(ACT_QUERY, 10'd3, 10'd1, 32'd0);
    send(ACT_QUERY, 10'd1, 10'd3, 32'd0);
    drain();
    write_length(11'd0);
    send(ACT_SET, 10'd0, 10'd0, 32'h7FFF_FFFF);
    send(ACT_SET, 10'd1, 10'd0, 32'h7FFF_FFFF);
    send(ACT_SET, 10'd2, 10'd0, 32'h7FFF_FFFF);
    send(ACT_QUERY, 10'd0, 10'd2, 32'd0);
    send(ACT_QUERY, 10'd0, 10'd3, 32'd0);
    drain();
    write_length(11'h7FF);
    send(ACT_SET, 10'd1022, 10'd0, 32'd0);
    send(ACT_SET, 10'd1023, 10'd0, 32'd0);
    send(ACT_QUERY, 10'd1000, 10'd1023, 32'd0);
    drain();
    write_length(11'd16);
    random_phase(150, 16);
    drain();
    write_length(11'd3);
    random_phase(60, 3);
    drain();
    write_length(11'd1024);
    random_phase(200, 1024);
    drain();
    write_length(11'd40);
    calm = 1;
    random_phase(90, 40);
    drain();
    $display("Covered %0d items and %0d query results over lengths 3 to 1024.",
             items_sent, board.answers);
    if (board.mismatches == 0 && board.want_found.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", board.mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
